// File: design/nkstat_pkg.sv
// ----------------------------------------------------------------------------
// nkstat_pkg
// Shared types, constants and helpers for the nucleotide statistics counter.
// ----------------------------------------------------------------------------
package nkstat_pkg;

  // Command codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_RD_PAIR = 2'd1,
    FUNC_RD_TRIP = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  // Output counter fields are fixed at 24 bits whatever the counter width
  localparam int unsigned CNT_FIELD_W = 24;
  typedef logic [CNT_FIELD_W-1:0] cnt_field_t;

  // djb2 hash
  localparam int unsigned HASH_W    = 64;
  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

  // Base codes
  typedef logic [1:0] base_code_t;
  localparam base_code_t CODE_A = 2'b00;
  localparam base_code_t CODE_C = 2'b01;
  localparam base_code_t CODE_G = 2'b10;
  localparam base_code_t CODE_T = 2'b11;

  // ASCII letters, slot 0 is A through slot 3 is T
  localparam logic [7:0] ASCII_A = 8'h41;
  localparam logic [7:0] ASCII_C = 8'h43;
  localparam logic [7:0] ASCII_G = 8'h47;
  localparam logic [7:0] ASCII_T = 8'h54;
  localparam logic [3:0][7:0] LETTERS = {ASCII_T, ASCII_G, ASCII_C, ASCII_A};

  // History depth saturates at two bases
  localparam logic [1:0] FILL_MAX = 2'd2;

  // Control for one counter bank
  typedef struct packed {
    logic accept;  // transaction accepted this cycle
    logic inc;     // accepted item bumps the addressed counter
    logic commit;  // item in the result stage is handed over
    logic clear;   // accepted item clears the bank
  } bank_ctl_t;

  // Map a byte to its 2-bit code; anything but C, G, T codes as A
  function automatic base_code_t base_code(input logic [7:0] b);
    base_code_t c;
    unique case (b)
      ASCII_C: c = CODE_C;
      ASCII_G: c = CODE_G;
      ASCII_T: c = CODE_T;
      default: c = CODE_A;
    endcase
    return c;
  endfunction

endpackage

// File: design/nkstat_if.sv
// ----------------------------------------------------------------------------
// nkstat_if
// Valid/ready channels for commands into and results out of the counter.
// ----------------------------------------------------------------------------
interface nkstat_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] base_byte;
  logic [5:0] counter_index;

  modport source (output valid, func, base_byte, counter_index, input ready);
  modport sink   (input valid, func, base_byte, counter_index, output ready);
endinterface

interface nkstat_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] running_hash;
  logic [23:0] a_total;
  logic [23:0] c_total;
  logic [23:0] g_total;
  logic [23:0] t_total;
  logic [23:0] bases_seen;
  logic [23:0] counter_value;

  modport source (output valid, running_hash, a_total, c_total, g_total, t_total,
                  bases_seen, counter_value, input ready);
  modport sink   (input valid, running_hash, a_total, c_total, g_total, t_total,
                  bases_seen, counter_value, output ready);
endinterface

// File: design/nkstat_cnt_bank.sv
// ----------------------------------------------------------------------------
// nkstat_cnt_bank
// Bank of saturating counters in a memory with per-entry valid bits. The
// entry is read when a transaction is accepted and the incremented value is
// written back when that transaction's result is handed over.
// ----------------------------------------------------------------------------
module nkstat_cnt_bank #(
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned CNT_W  = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nkstat_pkg::bank_ctl_t    ctl,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [CNT_W-1:0]         value
);

  localparam int unsigned DEPTH   = 1 << ADDR_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [CNT_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;

  logic [ADDR_W-1:0] addr_r;
  logic              inc_r;
  logic [CNT_W-1:0]  q_r;
  logic              ok_r;
  logic              byp_r;
  logic [CNT_W-1:0]  byp_val_r;

  logic [CNT_W-1:0]  eff;
  logic [CNT_W-1:0]  wr_val;
  logic              wr_en;

  // Current value of the addressed entry: bypass, stored or never written
  always_comb begin
    if (byp_r) begin
      eff = byp_val_r;
    end else if (ok_r) begin
      eff = q_r;
    end else begin
      eff = '0;
    end
  end

  // Saturating increment, written once when the result leaves
  assign wr_val = (eff == CNT_MAX) ? eff : eff + 1'b1;
  assign wr_en  = ctl.commit && inc_r;
  assign value  = eff;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wr_val;
    end
    if (ctl.accept) begin
      q_r       <= mem[rd_addr];
      byp_val_r <= wr_val;
    end
  end

  // Control and valid bits; clear wins over a concurrent write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      addr_r <= '0;
      inc_r  <= 1'b0;
      ok_r   <= 1'b0;
      byp_r  <= 1'b0;
    end else begin
      if (ctl.accept && ctl.clear) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (ctl.accept) begin
        addr_r <= rd_addr;
        inc_r  <= ctl.inc;
        ok_r   <= vld_r[rd_addr];
        byp_r  <= wr_en && (addr_r == rd_addr);
      end
    end
  end

endmodule

// File: design/nucleotide_kmer_stats_counter_core.sv
// ----------------------------------------------------------------------------
// nucleotide_kmer_stats_counter_core
// Nucleotide statistics: djb2 hash, letter counts, dinucleotide and codon
// counters with saturating increments, counter reads and clear.
// Throughput: one command per cycle while the result register is free or
// being emptied; the counter memories are read on accept and written back,
// with bypass, as the result is handed over.
// Reset: synchronous, clears all counters, history and the result stage;
// the hash restarts at 5381. Clear does the same but for the result stage.
// ----------------------------------------------------------------------------
module nucleotide_kmer_stats_counter_core #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  nkstat_in_if.sink           in_ch,
  nkstat_out_if.source        out_ch
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                             out_valid_r;
  nkstat_pkg::func_t                func_r;
  logic [nkstat_pkg::HASH_W-1:0]    hash_r;
  logic [COUNT_WIDTH-1:0]           let_cnt_r [4];
  logic [COUNT_WIDTH-1:0]           byte_cnt_r;
  nkstat_pkg::base_code_t           prev_code_r;
  nkstat_pkg::base_code_t           older_code_r;
  logic [1:0]                       fill_r;

  logic                             acc;
  logic                             commit;
  nkstat_pkg::func_t                func_in;
  logic                             is_push;
  logic                             is_clear;
  nkstat_pkg::base_code_t           code;
  logic [3:0]                       pair_idx;
  logic [5:0]                       trip_idx;
  logic [3:0]                       pair_addr;
  logic [5:0]                       trip_addr;
  nkstat_pkg::bank_ctl_t            pair_ctl;
  nkstat_pkg::bank_ctl_t            trip_ctl;
  logic [COUNT_WIDTH-1:0]           pair_val;
  logic [COUNT_WIDTH-1:0]           trip_val;
  logic [COUNT_WIDTH-1:0]           sel_val;

  // Handshake: the result register is free or being emptied
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign commit      = out_valid_r && out_ch.ready;

  // Decode the incoming command
  assign func_in  = nkstat_pkg::func_t'(in_ch.func);
  assign is_push  = (func_in == nkstat_pkg::FUNC_PUSH);
  assign is_clear = (func_in == nkstat_pkg::FUNC_CLEAR);
  assign code     = nkstat_pkg::base_code(in_ch.base_byte);
  assign pair_idx = {prev_code_r, code};
  assign trip_idx = {older_code_r, prev_code_r, code};

  // Counter bank addresses: k-mer index on push, requested index on read
  assign pair_addr = is_push ? pair_idx : in_ch.counter_index[3:0];
  assign trip_addr = is_push ? trip_idx : in_ch.counter_index;

  always_comb begin
    pair_ctl.accept = acc;
    pair_ctl.inc    = is_push && (fill_r != 2'd0);
    pair_ctl.commit = commit;
    pair_ctl.clear  = is_clear;
    trip_ctl.accept = acc;
    trip_ctl.inc    = is_push && (fill_r == nkstat_pkg::FILL_MAX);
    trip_ctl.commit = commit;
    trip_ctl.clear  = is_clear;
  end

  nkstat_cnt_bank #(
    .ADDR_W (4),
    .CNT_W  (COUNT_WIDTH)
  ) u_pair_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (pair_ctl),
    .rd_addr (pair_addr),
    .value   (pair_val)
  );

  nkstat_cnt_bank #(
    .ADDR_W (6),
    .CNT_W  (COUNT_WIDTH)
  ) u_trip_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (trip_ctl),
    .rd_addr (trip_addr),
    .value   (trip_val)
  );

  // Update hash, letter and byte counts and base history on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      func_r       <= nkstat_pkg::FUNC_CLEAR;
      hash_r       <= nkstat_pkg::HASH_SEED;
      byte_cnt_r   <= '0;
      prev_code_r  <= nkstat_pkg::CODE_A;
      older_code_r <= nkstat_pkg::CODE_A;
      fill_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        let_cnt_r[i] <= '0;
      end
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (commit) begin
        out_valid_r <= 1'b0;
      end
      if (acc) begin
        func_r <= func_in;
        if (is_clear) begin
          hash_r       <= nkstat_pkg::HASH_SEED;
          byte_cnt_r   <= '0;
          prev_code_r  <= nkstat_pkg::CODE_A;
          older_code_r <= nkstat_pkg::CODE_A;
          fill_r       <= '0;
          for (int i = 0; i < 4; i++) begin
            let_cnt_r[i] <= '0;
          end
        end else if (is_push) begin
          hash_r <= (hash_r << 5) + hash_r + nkstat_pkg::HASH_W'(in_ch.base_byte);
          if (byte_cnt_r != CNT_MAX) begin
            byte_cnt_r <= byte_cnt_r + 1'b1;
          end
          for (int i = 0; i < 4; i++) begin
            if ((in_ch.base_byte == nkstat_pkg::LETTERS[i]) && (let_cnt_r[i] != CNT_MAX)) begin
              let_cnt_r[i] <= let_cnt_r[i] + 1'b1;
            end
          end
          older_code_r <= prev_code_r;
          prev_code_r  <= code;
          if (fill_r != nkstat_pkg::FILL_MAX) begin
            fill_r <= fill_r + 2'd1;
          end
        end
      end
    end
  end

  // Select the counter shown on reads
  always_comb begin
    unique case (func_r)
      nkstat_pkg::FUNC_RD_PAIR: sel_val = pair_val;
      nkstat_pkg::FUNC_RD_TRIP: sel_val = trip_val;
      nkstat_pkg::FUNC_PUSH:    sel_val = '0;
      nkstat_pkg::FUNC_CLEAR:   sel_val = '0;
    endcase
  end

  // Drive the result channel from the state after the last transaction
  assign out_ch.valid         = out_valid_r;
  assign out_ch.running_hash  = hash_r;
  assign out_ch.a_total       = nkstat_pkg::cnt_field_t'(let_cnt_r[0]);
  assign out_ch.c_total       = nkstat_pkg::cnt_field_t'(let_cnt_r[1]);
  assign out_ch.g_total       = nkstat_pkg::cnt_field_t'(let_cnt_r[2]);
  assign out_ch.t_total       = nkstat_pkg::cnt_field_t'(let_cnt_r[3]);
  assign out_ch.bases_seen    = nkstat_pkg::cnt_field_t'(byte_cnt_r);
  assign out_ch.counter_value = nkstat_pkg::cnt_field_t'(sel_val);

`ifndef SYNTHESIS
  // A clear leaves the hash at its seed and no bytes counted
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_clear) |=> (hash_r == nkstat_pkg::HASH_SEED) && (byte_cnt_r == '0)
    && (fill_r == 2'd0))
    else $error("clear did not restore the reset state");

  // History fill tracks whether any byte has been seen
  a_fill_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    ((fill_r == 2'd0) == (byte_cnt_r == '0)) && (fill_r != 2'd3))
    else $error("history fill out of step with byte count");

  // Push and clear results never show a counter value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((func_r == nkstat_pkg::FUNC_PUSH) || (func_r == nkstat_pkg::FUNC_CLEAR)))
    |-> (out_ch.counter_value == '0))
    else $error("counter value nonzero on push or clear");
`endif

endmodule

// File: dv/nkstat_checker.sv
// ----------------------------------------------------------------------------
// nkstat_checker
// Watches the command and result channels of the nucleotide statistics
// counter. It keeps its own copy of the hash, letter, dinucleotide and codon
// tallies, works out the statistics each accepted command should report, and
// compares every handed-over result with the oldest one still due.
// ----------------------------------------------------------------------------
module nkstat_checker (
  input  logic   clk,
  input  logic   rst_n,
  nkstat_in_if   in_mon,
  nkstat_out_if  out_mon,
  output int     fail_count,
  output int     pending_count,
  output int     checked_count
);

  localparam int unsigned    CNT_W   = 24;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  // Statistics as reported on the result channel
  typedef struct {
    logic [nkstat_pkg::HASH_W-1:0] hash;
    nkstat_pkg::cnt_field_t        a_cnt;
    nkstat_pkg::cnt_field_t        c_cnt;
    nkstat_pkg::cnt_field_t        g_cnt;
    nkstat_pkg::cnt_field_t        t_cnt;
    nkstat_pkg::cnt_field_t        seen;
    nkstat_pkg::cnt_field_t        value;
  } stats_t;

  // Predicted block state
  logic [nkstat_pkg::HASH_W-1:0] hash_acc;
  logic [CNT_W-1:0]              letter_tally [4];
  logic [CNT_W-1:0]              byte_tally;
  nkstat_pkg::base_code_t        last_code;
  nkstat_pkg::base_code_t        second_code;
  logic [1:0]                    depth;
  logic [CNT_W-1:0]              pair_tally  [16];
  logic [CNT_W-1:0]              codon_tally [64];

  stats_t stats_due_q [$];

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  // Return every tally to its post-reset value
  function automatic void clear_tallies();
    hash_acc    = nkstat_pkg::HASH_SEED;
    byte_tally  = '0;
    last_code   = nkstat_pkg::CODE_A;
    second_code = nkstat_pkg::CODE_A;
    depth       = '0;
    foreach (letter_tally[k]) letter_tally[k] = '0;
    foreach (pair_tally[k])   pair_tally[k]   = '0;
    foreach (codon_tally[k])  codon_tally[k]  = '0;
  endfunction

  // Apply one command to the predicted state and return what it reports
  function automatic stats_t advance_stats(input nkstat_pkg::func_t f,
                                           input logic [7:0] b,
                                           input logic [5:0] idx);
    stats_t                 s;
    nkstat_pkg::base_code_t code;
    s.value = '0;
    case (f)
      nkstat_pkg::FUNC_PUSH: begin
        hash_acc = (hash_acc << 5) + hash_acc + {56'd0, b};
        // only exact capitals count as letters; anything else codes as A
        code = nkstat_pkg::CODE_A;
        for (int k = 0; k < 4; k++) begin
          if (b == nkstat_pkg::LETTERS[k]) begin
            letter_tally[k] = sat_bump(letter_tally[k]);
            code = nkstat_pkg::base_code_t'(k);
          end
        end
        byte_tally = sat_bump(byte_tally);
        if (depth >= 2'd1) begin
          pair_tally[{last_code, code}] = sat_bump(pair_tally[{last_code, code}]);
        end
        if (depth >= 2'd2) begin
          codon_tally[{second_code, last_code, code}] =
            sat_bump(codon_tally[{second_code, last_code, code}]);
        end
        second_code = last_code;
        last_code   = code;
        if (depth < nkstat_pkg::FILL_MAX) depth++;
      end
      nkstat_pkg::FUNC_RD_PAIR: s.value = nkstat_pkg::cnt_field_t'(pair_tally[idx[3:0]]);
      nkstat_pkg::FUNC_RD_TRIP: s.value = nkstat_pkg::cnt_field_t'(codon_tally[idx]);
      default:                  clear_tallies();
    endcase
    s.hash  = hash_acc;
    s.a_cnt = nkstat_pkg::cnt_field_t'(letter_tally[0]);
    s.c_cnt = nkstat_pkg::cnt_field_t'(letter_tally[1]);
    s.g_cnt = nkstat_pkg::cnt_field_t'(letter_tally[2]);
    s.t_cnt = nkstat_pkg::cnt_field_t'(letter_tally[3]);
    s.seen  = nkstat_pkg::cnt_field_t'(byte_tally);
    return s;
  endfunction

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, label, want, got);
    end
  endtask

  // Predict on command transactions, then compare result transactions
  always @(posedge clk) begin
    stats_t want;
    if (!rst_n) begin
      clear_tallies();
      stats_due_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        stats_due_q.push_back(advance_stats(nkstat_pkg::func_t'(in_mon.func),
                                            in_mon.base_byte, in_mon.counter_index));
      if (out_mon.valid && out_mon.ready) begin
        if (stats_due_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction with no command pending", $time);
        end else begin
          want = stats_due_q.pop_front();
          checked_count++;
          check_field("running_hash",  want.hash,        out_mon.running_hash);
          check_field("a_total",       64'(want.a_cnt),  64'(out_mon.a_total));
          check_field("c_total",       64'(want.c_cnt),  64'(out_mon.c_total));
          check_field("g_total",       64'(want.g_cnt),  64'(out_mon.g_total));
          check_field("t_total",       64'(want.t_cnt),  64'(out_mon.t_total));
          check_field("bases_seen",    64'(want.seen),   64'(out_mon.bases_seen));
          check_field("counter_value", 64'(want.value),  64'(out_mon.counter_value));
        end
      end
    end
    pending_count = stats_due_q.size();
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the nucleotide statistics counter with directed commands (letter
// and non-letter bytes, counter reads with stray index bits, clears) and
// then random base streams under three sender/receiver idle mixes, with long
// receiver holds that back the block up. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req_cnt;

  int n_push;
  int n_odd_byte;
  int n_pair_rd;
  int n_codon_rd;
  int n_clear;

  int fail_count;
  int pending_count;
  int checked_count;

  nkstat_in_if  in_ch ();
  nkstat_out_if out_ch ();

  nucleotide_kmer_stats_counter_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nkstat_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always #4 clk = ~clk;

  // Offer one command, idling first at the current rate, and hold it until taken
  task automatic offer(input nkstat_pkg::func_t f, input logic [7:0] b,
                       input logic [5:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= f;
    in_ch.base_byte     <= b;
    in_ch.counter_index <= idx;
    case (f)
      nkstat_pkg::FUNC_PUSH: begin
        n_push++;
        if (!(b inside {nkstat_pkg::ASCII_A, nkstat_pkg::ASCII_C,
                        nkstat_pkg::ASCII_G, nkstat_pkg::ASCII_T})) n_odd_byte++;
      end
      nkstat_pkg::FUNC_RD_PAIR: n_pair_rd++;
      nkstat_pkg::FUNC_RD_TRIP: n_codon_rd++;
      default:                  n_clear++;
    endcase
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly clean bases, some lowercase or N, some arbitrary bytes
  function automatic logic [7:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)      return nkstat_pkg::LETTERS[$urandom_range(0, 3)];
    else if (r < 90) return nkstat_pkg::LETTERS[$urandom_range(0, 3)] | 8'h20;
    else if (r < 92) return 8'h4E;
    else             return 8'($urandom);
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      offer(nkstat_pkg::FUNC_PUSH,    pick_base(),   6'($urandom));
    else if (r < 85) offer(nkstat_pkg::FUNC_RD_PAIR, 8'($urandom),  6'($urandom));
    else if (r < 99) offer(nkstat_pkg::FUNC_RD_TRIP, 8'($urandom),  6'($urandom));
    else             offer(nkstat_pkg::FUNC_CLEAR,   8'($urandom),  6'($urandom));
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input bit hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (hold) hold_req_cnt++;
    repeat (PHASE_ITEMS) send_random();
  endtask

  // Result side: random stalls, plus a long hold when requested
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int guard;
    in_ch.valid         = 1'b0;
    in_ch.func          = nkstat_pkg::FUNC_PUSH;
    in_ch.base_byte     = '0;
    in_ch.counter_index = '0;
    rst_n               = 1'b0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    hold_req_cnt        = 0;
    n_push = 0; n_odd_byte = 0; n_pair_rd = 0; n_codon_rd = 0; n_clear = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reads of the cleared banks
    offer(nkstat_pkg::FUNC_RD_PAIR, 8'hFF, 6'd0);
    offer(nkstat_pkg::FUNC_RD_TRIP, 8'h00, 6'h3F);
    // First bases fill the history before pairs and codons count
    offer(nkstat_pkg::FUNC_PUSH, nkstat_pkg::ASCII_A, 6'h3F);
    offer(nkstat_pkg::FUNC_PUSH, nkstat_pkg::ASCII_C, 6'h00);
    offer(nkstat_pkg::FUNC_PUSH, nkstat_pkg::ASCII_G, 6'h15);
    offer(nkstat_pkg::FUNC_PUSH, nkstat_pkg::ASCII_T, 6'h2A);
    // Lowercase, zero, all-ones and N bytes code as A with no letter count
    offer(nkstat_pkg::FUNC_PUSH, 8'h61, 6'h00);
    offer(nkstat_pkg::FUNC_PUSH, 8'h00, 6'h00);
    offer(nkstat_pkg::FUNC_PUSH, 8'hFF, 6'h3F);
    offer(nkstat_pkg::FUNC_PUSH, 8'h4E, 6'h00);
    // Dinucleotide read ignores the upper index bits; then codon reads
    offer(nkstat_pkg::FUNC_RD_PAIR, 8'h00, 6'b110001);
    offer(nkstat_pkg::FUNC_RD_PAIR, 8'hFF, 6'd15);
    offer(nkstat_pkg::FUNC_RD_TRIP, 8'h00, 6'b000110);
    offer(nkstat_pkg::FUNC_RD_TRIP, 8'hFF, 6'd63);
    // Clear, then rebuild history from scratch
    offer(nkstat_pkg::FUNC_CLEAR,   8'hFF, 6'h3F);
    offer(nkstat_pkg::FUNC_RD_PAIR, 8'h00, 6'd1);
    offer(nkstat_pkg::FUNC_PUSH,    nkstat_pkg::ASCII_T, 6'h00);
    offer(nkstat_pkg::FUNC_PUSH,    nkstat_pkg::ASCII_T, 6'h00);
    offer(nkstat_pkg::FUNC_RD_PAIR, 8'h00, 6'd15);
    offer(nkstat_pkg::FUNC_PUSH,    nkstat_pkg::ASCII_T, 6'h00);
    offer(nkstat_pkg::FUNC_RD_TRIP, 8'h00, 6'd63);
    offer(nkstat_pkg::FUNC_CLEAR,   8'h00, 6'h00);

    // Random: slow receiver then slow sender, then full rate
    run_phase(36, 54, 1'b1);
    run_phase(54, 36, 1'b0);
    run_phase(0,  0,  1'b1);

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    guard = 0;
    while (pending_count != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);

    $display("Summary: %0d pushes (%0d non-ACGT bytes), %0d dinucleotide reads,",
             n_push, n_odd_byte, n_pair_rd);
    $display("Summary: %0d codon reads, %0d clears, %0d results checked over %s",
             n_codon_rd, n_clear, checked_count,
             "three idle mixes and two long output holds");
    if (pending_count != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
